@@ hw/rtl/ppm_frame_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// ppm frame decoder assertion macros
// concurrent checks on the clock and reset of the decoder top level
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
`define PPMFD_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ppm frame decoder check failed");
`define PPMFD_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("ppm frame decoder reset check failed");
`else
`define PPMFD_ASSERT(name, prop)
`define PPMFD_ASSERT_RST(name, prop)
`endif

`endif

@@ hw/rtl/ppmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm frame decoder package
// shared sizes, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ppmfd_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

   localparam int TIME_W       = 32;
   localparam int WIDTH_W      = 16;
   localparam int CHAN_NUM_W   = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 24;

   localparam logic [WIDTH_W-1:0]    IDLE_WIDTH      = 16'd1500;
   localparam logic [WIDTH_W-1:0]    WIDTH_CAP       = 16'hFFFF;
   localparam logic [CHAN_NUM_W-1:0] RST_CHAN_COUNT  = 4'd0;
   localparam logic [WIDTH_W-1:0]    RST_SYNC_GAP    = 16'd3500;
   localparam logic [WIDTH_W-1:0]    RST_MIN_WIDTH   = 16'd800;
   localparam logic [WIDTH_W-1:0]    RST_MAX_WIDTH   = 16'd2200;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHANNEL_COUNT = 2'd0,
      REG_SYNC_GAP      = 2'd1,
      REG_MIN_WIDTH     = 2'd2,
      REG_MAX_WIDTH     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic             take_edge;
      logic             capture;
      logic             commit;
      logic             emit;
      logic             emit_last;
      logic [CNT_W-1:0] emit_idx;
   } cmd_type;

   typedef struct packed {
      logic             is_sync;
      logic             slots_nonzero;
      logic             out_free;
      logic [CNT_W-1:0] chans;
   } status_type;

endpackage

@@ hw/rtl/ppmfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppm frame decoder controller
// sequences edge intake, gap evaluation and the per-channel beat emission
// ----------------------------------------------------------------------------
module ppmfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ppmfd_pkg::status_type status,
   output ppmfd_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [ppmfd_pkg::CNT_W-1:0] emit_idx_ff, emit_idx_in;
   logic [ppmfd_pkg::CNT_W-1:0] idx_next;

   assign idx_next   = emit_idx_ff + ppmfd_pkg::CNT_W'(1);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      emit_idx_in   = emit_idx_ff;
      cmd           = '0;
      cmd.emit_idx  = emit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take_edge = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            emit_idx_in = '0;
            if (status.is_sync) begin
               cmd.commit = 1'b1;
               if (status.slots_nonzero && (status.chans != '0)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (idx_next == status.chans);
               emit_idx_in   = idx_next;
               if (idx_next == status.chans) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

endmodule

@@ hw/rtl/ppmfd_datapath.sv @@
// ----------------------------------------------------------------------------
// ppm frame decoder datapath
// settings, edge delta, width clamp, capture and stable slots, output beat
// ----------------------------------------------------------------------------
module ppmfd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppmfd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [ppmfd_pkg::TIME_W-1:0]        edge_time,
   input  ppmfd_pkg::cmd_type                  cmd,
   output ppmfd_pkg::status_type               status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [ppmfd_pkg::CHAN_NUM_W-1:0]    rsp_number,
   output logic [ppmfd_pkg::WIDTH_W-1:0]       rsp_value,
   output logic                                rsp_last
);

   logic [ppmfd_pkg::CHAN_NUM_W-1:0] chan_count_ff;
   logic [ppmfd_pkg::WIDTH_W-1:0]    sync_gap_ff;
   logic [ppmfd_pkg::WIDTH_W-1:0]    min_width_ff;
   logic [ppmfd_pkg::WIDTH_W-1:0]    max_width_ff;

   logic [ppmfd_pkg::TIME_W-1:0]     prev_edge_ff;
   logic [ppmfd_pkg::TIME_W-1:0]     delta_ff;
   logic [ppmfd_pkg::CNT_W-1:0]      slot_idx_ff;
   logic [ppmfd_pkg::WIDTH_W-1:0]    capture_ff [ppmfd_pkg::MAX_CHANNELS];
   logic [ppmfd_pkg::WIDTH_W-1:0]    stable_ff  [ppmfd_pkg::MAX_CHANNELS];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ppmfd_pkg::CHAN_NUM_W-1:0] rsp_number_ff;
   logic [ppmfd_pkg::WIDTH_W-1:0]    rsp_value_ff;
   logic                             rsp_last_ff;

   logic [ppmfd_pkg::CNT_W-1:0]      chans;
   logic [ppmfd_pkg::CNT_W-1:0]      copy_n;
   logic [ppmfd_pkg::WIDTH_W-1:0]    sat_width;
   logic [ppmfd_pkg::WIDTH_W-1:0]    low_width;
   logic [ppmfd_pkg::WIDTH_W-1:0]    clamp_width;

   always_comb begin
      if (ppmfd_pkg::CNT_W'(chan_count_ff) > ppmfd_pkg::CNT_W'(ppmfd_pkg::MAX_CHANNELS)) begin
         chans = ppmfd_pkg::CNT_W'(ppmfd_pkg::MAX_CHANNELS);
      end else begin
         chans = ppmfd_pkg::CNT_W'(chan_count_ff);
      end
   end

   assign copy_n = (slot_idx_ff > chans) ? chans : slot_idx_ff;

   // saturate, raise to the lower clamp, then lower to the upper clamp
   assign sat_width   = (|delta_ff[ppmfd_pkg::TIME_W-1:ppmfd_pkg::WIDTH_W]) ?
                        ppmfd_pkg::WIDTH_CAP : delta_ff[ppmfd_pkg::WIDTH_W-1:0];
   assign low_width   = (sat_width < min_width_ff) ? min_width_ff : sat_width;
   assign clamp_width = (low_width > max_width_ff) ? max_width_ff : low_width;

   assign status.is_sync       = (delta_ff >= ppmfd_pkg::TIME_W'(sync_gap_ff));
   assign status.slots_nonzero = (slot_idx_ff != '0);
   assign status.out_free      = !rsp_valid_ff || rsp_ready;
   assign status.chans         = chans;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= ppmfd_pkg::RST_CHAN_COUNT;
         sync_gap_ff   <= ppmfd_pkg::RST_SYNC_GAP;
         min_width_ff  <= ppmfd_pkg::RST_MIN_WIDTH;
         max_width_ff  <= ppmfd_pkg::RST_MAX_WIDTH;
      end else if (csr_wr_en) begin
         case (csr_index)
            ppmfd_pkg::REG_CHANNEL_COUNT: begin
               chan_count_ff <= csr_wdata[ppmfd_pkg::CHAN_NUM_W-1:0];
            end
            ppmfd_pkg::REG_SYNC_GAP: begin
               sync_gap_ff <= csr_wdata[ppmfd_pkg::WIDTH_W-1:0];
            end
            ppmfd_pkg::REG_MIN_WIDTH: begin
               min_width_ff <= csr_wdata[ppmfd_pkg::WIDTH_W-1:0];
            end
            ppmfd_pkg::REG_MAX_WIDTH: begin
               max_width_ff <= csr_wdata[ppmfd_pkg::WIDTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_edge_ff <= '0;
         slot_idx_ff  <= '0;
         for (int i = 0; i < ppmfd_pkg::MAX_CHANNELS; i++) begin
            capture_ff[i] <= ppmfd_pkg::IDLE_WIDTH;
            stable_ff[i]  <= ppmfd_pkg::IDLE_WIDTH;
         end
      end else begin
         if (cmd.take_edge) begin
            prev_edge_ff <= edge_time;
         end
         if (cmd.capture && (slot_idx_ff < chans)) begin
            capture_ff[slot_idx_ff[ppmfd_pkg::IDX_W-1:0]] <= clamp_width;
            slot_idx_ff <= slot_idx_ff + ppmfd_pkg::CNT_W'(1);
         end
         if (cmd.commit) begin
            for (int i = 0; i < ppmfd_pkg::MAX_CHANNELS; i++) begin
               if (ppmfd_pkg::CNT_W'(i) < copy_n) begin
                  stable_ff[i] <= capture_ff[i];
               end
            end
            slot_idx_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_edge) begin
         delta_ff <= edge_time - prev_edge_ff;
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_number_ff <= ppmfd_pkg::CHAN_NUM_W'(cmd.emit_idx + ppmfd_pkg::CNT_W'(1));
         rsp_value_ff  <= stable_ff[cmd.emit_idx[ppmfd_pkg::IDX_W-1:0]];
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ hw/rtl/ppm_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ppm frame decoder
// Each req beat carries the microsecond timestamp of one stream edge. The
// gap from the previous edge either captures one clamped channel width
// while slots remain or, at or above the sync gap, commits the captured
// frame and, if any width was captured, sends one rsp beat per configured
// channel, tlast on the final one. Timing: an edge is taken in the idle
// cycle and its gap is evaluated in the next cycle. The emit sequencer
// reloads the output register once per cycle, one beat each, while the
// receiver keeps tready high; the first rsp beat is loaded in the emit
// state that follows the evaluation of the committing req beat. A receiver
// stall holds the current rsp beat and pauses emission; req tready stays
// low until the last beat of the frame is loaded. Reset returns the
// settings to their defaults, clears the slot index and previous edge and
// fills both slot stores with 1500. Settings are to be written on the csr
// port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_defines.svh"

module ppm_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // csr write port
   input  logic                                 csr_wr_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppmfd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // edge beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ppmfd_pkg::REQ_DATA_W-1:0]     req_tdata,  // edge_time_us[31:0]
   // channel beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ppmfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // channel_number[3:0], channel_value[19:4], zero pad
   output logic                                 rsp_tlast   // last_channel
);

   ppmfd_pkg::cmd_type                 cmd;
   ppmfd_pkg::status_type              status;
   logic [ppmfd_pkg::CHAN_NUM_W-1:0]   rsp_number;
   logic [ppmfd_pkg::WIDTH_W-1:0]      rsp_value;

   ppmfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppmfd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .edge_time  (req_tdata[ppmfd_pkg::TIME_W-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_number (rsp_number),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {
      (ppmfd_pkg::RSP_DATA_W - ppmfd_pkg::WIDTH_W - ppmfd_pkg::CHAN_NUM_W)'(0),
      rsp_value,
      rsp_number
   };

   `PPMFD_ASSERT(a_emit_free, (cmd.emit |-> (!rsp_tvalid || rsp_tready)))
   `PPMFD_ASSERT(a_no_emit_idle, (req_tready |-> !cmd.emit))
   `PPMFD_ASSERT(a_last_idle, ((cmd.emit && cmd.emit_last) |=> req_tready))
   `PPMFD_ASSERT_RST(a_reset_clear, (reset |=> (!rsp_tvalid && req_tready)))

endmodule
